### rtl/core/psrt_pkg.sv
// ----------------------------------------------------------------------------
// Power state residency tracker package
// Shared payload types, register constants and state decoding functions.
// ----------------------------------------------------------------------------
package psrt_pkg;

   localparam int DOMAIN_INDEX_WIDTH = 6;
   localparam int DURATION_WIDTH     = 48;
   localparam int LIMIT_WIDTH        = 3;
   localparam int CSR_DATA_WIDTH     = 32;
   localparam int CSR_ADDR_WIDTH     = 3;

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET     = 3'd4;
   localparam logic                   CSR_LIMIT_INDEX = 1'b0;

   localparam logic CMD_EVENT    = 1'b0;
   localparam logic CMD_FLUSH    = 1'b1;
   localparam logic CLASS_LOGIC  = 1'b0;
   localparam logic CLASS_MEMORY = 1'b1;

   typedef struct packed {
      logic        command;
      logic        event_class;
      logic [31:0] states_high;
      logic [31:0] states_low;
      logic [31:0] time_delta;
   } req_type;

   typedef struct packed {
      logic [DOMAIN_INDEX_WIDTH-1:0] domain_index;
      logic [1:0]                    held_state;
      logic [DURATION_WIDTH-1:0]     held_duration;
      logic                          error_flag;
      logic                          last_of_run;
   } rsp_type;

   typedef struct packed {
      req_type                       req;
      logic                          error;
      logic [DOMAIN_INDEX_WIDTH-1:0] error_domain;
      logic [1:0]                    error_state;
   } item_type;

   typedef struct packed {
      logic     empty;
      item_type item;
   } queue_out_type;

   // Logic domain p sits at bits 2*(15-p); 15-p is the inverse of a 4-bit p.
   function automatic logic [1:0] logic_state(logic [31:0] word, logic [3:0] pos);
      return word[{~pos, 1'b0} +: 2];
   endfunction

   // Memory domain m sits at bits 2*(31-m) of the high and low words joined.
   function automatic logic [1:0] memory_state(logic [63:0] word, logic [4:0] pos);
      return word[{~pos, 1'b0} +: 2];
   endfunction

endpackage

### rtl/core/psrt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/psrt_fifo.sv
// ----------------------------------------------------------------------------
// Small register FIFO
// A short first-in first-out queue of words held in flip-flops.
// ----------------------------------------------------------------------------
module psrt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/core/psrt_front.sv
// ----------------------------------------------------------------------------
// Residency tracker front end
// Accepts events and flushes, checks every decoded state of an event against
// the limit and queues the classified word for the back end.
// ----------------------------------------------------------------------------
module psrt_front #(
   parameter int LOGIC_DOMAINS  = 16,
   parameter int MEMORY_DOMAINS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  psrt_pkg::req_type                  req_data,
   output logic                               full,
   input  logic [psrt_pkg::LIMIT_WIDTH-1:0]   limit,
   input  logic                               queue_pop,
   output psrt_pkg::queue_out_type            queue_out
);

   localparam int IDX_W = psrt_pkg::DOMAIN_INDEX_WIDTH;
   localparam int ITEM_W = $bits(psrt_pkg::item_type);

   psrt_pkg::item_type item;
   logic [ITEM_W-1:0]  queue_data;
   logic               queue_empty;
   logic [1:0]         st;
   logic               bad;

   always_comb begin
      item.req          = req_data;
      item.error        = 1'b0;
      item.error_domain = '0;
      item.error_state  = '0;
      st                = '0;
      bad               = 1'b0;
      if (req_data.command == psrt_pkg::CMD_EVENT) begin
         if (req_data.event_class == psrt_pkg::CLASS_LOGIC) begin
            for (int p = LOGIC_DOMAINS - 1; p >= 0; p--) begin
               st  = psrt_pkg::logic_state(req_data.states_low, 4'(p));
               bad = ({1'b0, st} >= limit);
               if (bad) begin
                  item.error        = 1'b1;
                  item.error_domain = IDX_W'(p);
                  item.error_state  = st;
               end
            end
         end else begin
            for (int m = MEMORY_DOMAINS - 1; m >= 0; m--) begin
               st  = psrt_pkg::memory_state({req_data.states_high, req_data.states_low},
                                            5'(m));
               bad = ({1'b0, st} >= limit);
               if (bad) begin
                  item.error        = 1'b1;
                  item.error_domain = IDX_W'(LOGIC_DOMAINS + m);
                  item.error_state  = st;
               end
            end
         end
      end
   end

   psrt_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (2)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (item),
      .full    (full),
      .pop     (queue_pop),
      .rd_data (queue_data),
      .empty   (queue_empty)
   );

   assign queue_out = '{empty: queue_empty, item: psrt_pkg::item_type'(queue_data)};

endmodule

### rtl/core/psrt_back.sv
// ----------------------------------------------------------------------------
// Residency tracker back end
// Walks each event or flush one domain a cycle through the state RAM while
// results have room; emits change, flush and error records; keeps running time.
// ----------------------------------------------------------------------------
module psrt_back #(
   parameter int LOGIC_DOMAINS  = 16,
   parameter int MEMORY_DOMAINS = 32,
   parameter int TIME_WIDTH     = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   input  psrt_pkg::queue_out_type queue_out,
   output logic                    queue_pop,
   output logic                    rsp_push,
   output psrt_pkg::rsp_type       rsp_record,
   input  logic                    rsp_full
);

   localparam int ALL_DOMAINS = LOGIC_DOMAINS + MEMORY_DOMAINS;
   localparam int IDX_W       = psrt_pkg::DOMAIN_INDEX_WIDTH;
   localparam int ADDR_W      = $clog2(ALL_DOMAINS);
   localparam int RAM_W       = TIME_WIDTH + 2;
   localparam logic [IDX_W-1:0] ALL_IDX   = IDX_W'(ALL_DOMAINS);
   localparam logic [IDX_W-1:0] LOGIC_IDX = IDX_W'(LOGIC_DOMAINS);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ERROR  = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   psrt_pkg::item_type      item_ff, item_in;
   logic [IDX_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0]        end_ff, end_in;
   logic [IDX_W-1:0]        base_ff, base_in;
   logic                    eval_valid_ff, eval_valid_in;
   logic [IDX_W-1:0]        eval_dom_ff, eval_dom_in;
   logic                    pend_valid_ff, pend_valid_in;
   psrt_pkg::rsp_type       pend_ff, pend_in;
   logic [TIME_WIDTH-1:0]   run_ff, run_in;
   logic [ALL_DOMAINS-1:0]  seen_ff, seen_in;

   logic                    advance;
   logic                    rd_en, wr_en;
   logic [RAM_W-1:0]        rd_data, wr_data;
   logic                    seen;
   logic [1:0]              cur_state, new_state;
   logic [TIME_WIDTH-1:0]   last_time;
   logic [IDX_W-1:0]        pos;
   logic                    new_rec;
   psrt_pkg::rsp_type       rec;

   assign advance   = !rsp_full;
   assign seen      = seen_ff[eval_dom_ff[ADDR_W-1:0]];
   assign cur_state = seen ? rd_data[TIME_WIDTH +: 2] : 2'b00;
   assign last_time = seen ? rd_data[TIME_WIDTH-1:0] : '0;
   assign pos       = eval_dom_ff - base_ff;

   always_comb begin
      if (item_ff.req.event_class == psrt_pkg::CLASS_LOGIC) begin
         new_state = psrt_pkg::logic_state(item_ff.req.states_low, pos[3:0]);
      end else begin
         new_state = psrt_pkg::memory_state({item_ff.req.states_high,
                                             item_ff.req.states_low}, pos[4:0]);
      end
   end

   always_comb begin
      rec.domain_index  = eval_dom_ff;
      rec.held_state    = cur_state;
      rec.held_duration = psrt_pkg::DURATION_WIDTH'(run_ff - last_time);
      rec.error_flag    = 1'b0;
      rec.last_of_run   = 1'b0;
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      rd_ptr_in     = rd_ptr_ff;
      end_in        = end_ff;
      base_in       = base_ff;
      eval_valid_in = eval_valid_ff;
      eval_dom_in   = eval_dom_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      run_in        = run_ff;
      seen_in       = seen_ff;
      queue_pop     = 1'b0;
      rsp_push      = 1'b0;
      rsp_record    = pend_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_data       = {new_state, run_ff};
      new_rec       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            eval_valid_in = 1'b0;
            if (!queue_out.empty) begin
               queue_pop = 1'b1;
               item_in   = queue_out.item;
               if (queue_out.item.req.command == psrt_pkg::CMD_FLUSH) begin
                  rd_ptr_in = '0;
                  base_in   = '0;
                  end_in    = ALL_IDX;
                  state_in  = ST_SCAN;
               end else if (queue_out.item.error) begin
                  state_in = ST_ERROR;
               end else if (queue_out.item.req.event_class == psrt_pkg::CLASS_LOGIC) begin
                  rd_ptr_in = '0;
                  base_in   = '0;
                  end_in    = LOGIC_IDX;
                  state_in  = ST_SCAN;
               end else begin
                  rd_ptr_in = LOGIC_IDX;
                  base_in   = LOGIC_IDX;
                  end_in    = ALL_IDX;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_ERROR: begin
            rsp_record.domain_index  = item_ff.error_domain;
            rsp_record.held_state    = item_ff.error_state;
            rsp_record.held_duration = '0;
            rsp_record.error_flag    = 1'b1;
            rsp_record.last_of_run   = 1'b1;
            if (advance) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (advance) begin
               if (eval_valid_ff) begin
                  if (item_ff.req.command == psrt_pkg::CMD_FLUSH) begin
                     new_rec = (last_time != run_ff);
                  end else if (!seen) begin
                     seen_in[eval_dom_ff[ADDR_W-1:0]] = 1'b1;
                     wr_en   = 1'b1;
                     wr_data = {new_state, {TIME_WIDTH{1'b0}}};
                  end else if (new_state != cur_state) begin
                     new_rec = 1'b1;
                     wr_en   = 1'b1;
                  end
                  if (new_rec) begin
                     rsp_push      = pend_valid_ff;
                     pend_in       = rec;
                     pend_valid_in = 1'b1;
                  end
               end
               if (rd_ptr_ff != end_ff) begin
                  rd_en         = 1'b1;
                  rd_ptr_in     = rd_ptr_ff + 1'b1;
                  eval_valid_in = 1'b1;
                  eval_dom_in   = rd_ptr_ff;
               end else begin
                  eval_valid_in = 1'b0;
                  if (!eval_valid_ff) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_FINISH: begin
            rsp_record.last_of_run = 1'b1;
            if (advance) begin
               rsp_push      = pend_valid_ff;
               pend_valid_in = 1'b0;
               if (item_ff.req.command == psrt_pkg::CMD_FLUSH) begin
                  seen_in = '0;
                  run_in  = '0;
               end else begin
                  run_in = run_ff + TIME_WIDTH'(item_ff.req.time_delta);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         eval_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         run_ff        <= '0;
         seen_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         eval_valid_ff <= eval_valid_in;
         pend_valid_ff <= pend_valid_in;
         run_ff        <= run_in;
         seen_ff       <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rd_ptr_ff   <= rd_ptr_in;
      end_ff      <= end_in;
      base_ff     <= base_in;
      eval_dom_ff <= eval_dom_in;
      pend_ff     <= pend_in;
   end

   psrt_ram #(
      .WIDTH (RAM_W),
      .DEPTH (ALL_DOMAINS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (eval_dom_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

endmodule

### rtl/core/power_state_residency_tracker_core.sv
// ----------------------------------------------------------------------------
// Power state residency tracker core
// Tracks per-domain power states and reports how long each state was held.
// ----------------------------------------------------------------------------
// An event over N domains occupies the back end while it walks them, one
// domain a cycle through the state RAM unless the result queue is full; a
// flush walks all domains and an error word none. Each record waits for the
// next record of its word or the end of the scan, so the last one goes into
// the result queue as its word finishes. Reset clears the queues, seen bits
// and running time at once and sets the limit to 4.
// ----------------------------------------------------------------------------
module power_state_residency_tracker_core #(
   parameter int LOGIC_DOMAINS  = 16,
   parameter int MEMORY_DOMAINS = 32,
   parameter int TIME_WIDTH     = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  psrt_pkg::req_type                    req_data,
   output logic                                 full,
   output logic                                 empty,
   input  logic                                 pop,
   output psrt_pkg::rsp_type                    rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [psrt_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [psrt_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [psrt_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                 pready
);

   localparam int RSP_W = $bits(psrt_pkg::rsp_type);

   logic [psrt_pkg::LIMIT_WIDTH-1:0] limit_ff, limit_in;
   logic                             limit_sel;
   psrt_pkg::queue_out_type          queue_out;
   logic                             queue_pop;
   logic                             rsp_push;
   logic                             rsp_full;
   psrt_pkg::rsp_type                rsp_record;
   logic [RSP_W-1:0]                 rsp_word;

   assign pready    = 1'b1;
   assign limit_sel = (paddr[2] == psrt_pkg::CSR_LIMIT_INDEX);
   assign prdata    = limit_sel ? psrt_pkg::CSR_DATA_WIDTH'(limit_ff) : '0;

   always_comb begin
      limit_in = limit_ff;
      if (psel && penable && pwrite && limit_sel) begin
         limit_in = pwdata[psrt_pkg::LIMIT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= psrt_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   psrt_front #(
      .LOGIC_DOMAINS  (LOGIC_DOMAINS),
      .MEMORY_DOMAINS (MEMORY_DOMAINS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .limit     (limit_ff),
      .queue_pop (queue_pop),
      .queue_out (queue_out)
   );

   psrt_back #(
      .LOGIC_DOMAINS  (LOGIC_DOMAINS),
      .MEMORY_DOMAINS (MEMORY_DOMAINS),
      .TIME_WIDTH     (TIME_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .queue_out  (queue_out),
      .queue_pop  (queue_pop),
      .rsp_push   (rsp_push),
      .rsp_record (rsp_record),
      .rsp_full   (rsp_full)
   );

   psrt_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_record),
      .full    (rsp_full),
      .pop     (pop),
      .rd_data (rsp_word),
      .empty   (empty)
   );

   assign rsp_data = psrt_pkg::rsp_type'(rsp_word);

endmodule

### sim/power_state_residency_tracker_core_tb.sv
// ----------------------------------------------------------------------------
// Power state residency tracker core testbench
// Drives power events and end-of-trace flushes through the request queue,
// sets the state limit over the register port, predicts every residency
// record in the testbench and checks each popped word field by field, with
// random gaps on both queues.
// ----------------------------------------------------------------------------
module power_state_residency_tracker_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LOGIC_COUNT   = 16;
   localparam int MEMORY_COUNT  = 32;
   localparam int DOMAIN_COUNT  = LOGIC_COUNT + MEMORY_COUNT;
   localparam int GAP_MAX       = 18;
   localparam int SETTLE_CYCLES = 400;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [psrt_pkg::CSR_ADDR_WIDTH-1:0] LIMIT_ADDR =
      {psrt_pkg::CSR_LIMIT_INDEX, 2'b00};
   localparam logic [psrt_pkg::CSR_ADDR_WIDTH-1:0] SPARE_ADDR =
      {~psrt_pkg::CSR_LIMIT_INDEX, 2'b00};

   logic                                clock;
   logic                                reset;
   logic                                push;
   psrt_pkg::req_type                   req_data;
   logic                                full;
   logic                                empty;
   logic                                pop;
   psrt_pkg::rsp_type                   rsp_data;
   logic                                psel;
   logic                                penable;
   logic                                pwrite;
   logic [psrt_pkg::CSR_ADDR_WIDTH-1:0] paddr;
   logic [psrt_pkg::CSR_DATA_WIDTH-1:0] pwdata;
   logic [psrt_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic                                pready;

   logic [1:0]                          dom_state [DOMAIN_COUNT];
   logic [psrt_pkg::DURATION_WIDTH-1:0] dom_since [DOMAIN_COUNT];
   bit                                  dom_seen  [DOMAIN_COUNT];
   logic [psrt_pkg::DURATION_WIDTH-1:0] trace_time;
   logic [psrt_pkg::LIMIT_WIDTH-1:0]    state_limit;

   psrt_pkg::rsp_type due_records[$];
   int unsigned       mismatch_count;
   int unsigned       cycle_count;
   bit                send_burst;
   logic [63:0]       logic_pattern;
   logic [63:0]       memory_pattern;

   power_state_residency_tracker_core u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic void clear_tracker();
      for (int d = 0; d < DOMAIN_COUNT; d++) begin
         dom_state[d] = 2'd0;
         dom_since[d] = '0;
         dom_seen[d]  = 1'b0;
      end
      trace_time = '0;
   endfunction

   function automatic logic [1:0] domain_state(logic cls, int unsigned pos,
                                               logic [31:0] hi, logic [31:0] lo);
      if (cls == psrt_pkg::CLASS_LOGIC)
         return lo[2*(15-pos) +: 2];
      if (pos < 16)
         return hi[2*(15-pos) +: 2];
      return lo[2*(31-pos) +: 2];
   endfunction

   function automatic void track_residency(psrt_pkg::req_type w);
      psrt_pkg::rsp_type rec;
      psrt_pkg::rsp_type batch[$];
      int unsigned       n_dom;
      int unsigned       base;
      logic [1:0]        st;
      rec = '0;
      if (w.command == psrt_pkg::CMD_FLUSH) begin
         for (int d = 0; d < DOMAIN_COUNT; d++) begin
            if (dom_since[d] != trace_time) begin
               rec.domain_index  = psrt_pkg::DOMAIN_INDEX_WIDTH'(d);
               rec.held_state    = dom_state[d];
               rec.held_duration = trace_time - dom_since[d];
               batch.push_back(rec);
            end
         end
         clear_tracker();
      end else begin
         n_dom = (w.event_class == psrt_pkg::CLASS_MEMORY) ? MEMORY_COUNT : LOGIC_COUNT;
         base  = (w.event_class == psrt_pkg::CLASS_MEMORY) ? LOGIC_COUNT : 0;
         for (int p = 0; p < n_dom; p++) begin
            st = domain_state(w.event_class, p, w.states_high, w.states_low);
            if ({1'b0, st} >= state_limit) begin
               rec.domain_index  = psrt_pkg::DOMAIN_INDEX_WIDTH'(base + p);
               rec.held_state    = st;
               rec.held_duration = '0;
               rec.error_flag    = 1'b1;
               rec.last_of_run   = 1'b1;
               due_records.push_back(rec);
               return;
            end
         end
         for (int p = 0; p < n_dom; p++) begin
            st = domain_state(w.event_class, p, w.states_high, w.states_low);
            if (!dom_seen[base+p]) begin
               dom_seen[base+p]  = 1'b1;
               dom_state[base+p] = st;
            end else if (st != dom_state[base+p]) begin
               rec.domain_index  = psrt_pkg::DOMAIN_INDEX_WIDTH'(base + p);
               rec.held_state    = dom_state[base+p];
               rec.held_duration = trace_time - dom_since[base+p];
               batch.push_back(rec);
               dom_state[base+p] = st;
               dom_since[base+p] = trace_time;
            end
         end
         trace_time = trace_time + psrt_pkg::DURATION_WIDTH'(w.time_delta);
      end
      if (batch.size() > 0) begin
         rec = batch.pop_back();
         rec.last_of_run = 1'b1;
         batch.push_back(rec);
      end
      foreach (batch[i])
         due_records.push_back(batch[i]);
   endfunction

   function automatic void check_record(psrt_pkg::rsp_type got);
      psrt_pkg::rsp_type want;
      if (due_records.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected word: domain %0d state %0d duration %0d error %0b last %0b",
                     got.domain_index, got.held_state, got.held_duration,
                     got.error_flag, got.last_of_run);
         return;
      end
      want = due_records.pop_front();
      if (got.domain_index !== want.domain_index || got.held_state !== want.held_state ||
          got.held_duration !== want.held_duration ||
          got.error_flag !== want.error_flag || got.last_of_run !== want.last_of_run) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("word mismatch, expected: domain %0d state %0d duration %0d err %0b last %0b",
                     want.domain_index, want.held_state, want.held_duration,
                     want.error_flag, want.last_of_run);
            $display("                 actual: domain %0d state %0d duration %0d err %0b last %0b",
                     got.domain_index, got.held_state, got.held_duration,
                     got.error_flag, got.last_of_run);
         end
      end
   endfunction

   function automatic int unsigned draw_gap(bit burst);
      return burst ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   function automatic logic [31:0] draw_delta();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1, 16);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [63:0] mutate_states(logic [63:0] old, int unsigned slots,
                                                 logic [psrt_pkg::LIMIT_WIDTH-1:0] lim);
      logic [63:0] w;
      int unsigned top;
      w   = old;
      top = (lim >= 4 || lim == 0) ? 3 : lim - 1;
      for (int i = 0; i < slots; i++) begin
         if ({1'b0, w[2*i +: 2]} >= lim || $urandom_range(0, 3) == 0)
            w[2*i +: 2] = 2'($urandom_range(0, top));
      end
      return w;
   endfunction

   function automatic psrt_pkg::req_type make_word(logic cmd, logic cls, logic [31:0] hi,
                                                   logic [31:0] lo, logic [31:0] delta);
      psrt_pkg::req_type w;
      w.command     = cmd;
      w.event_class = cls;
      w.states_high = hi;
      w.states_low  = lo;
      w.time_delta  = delta;
      return w;
   endfunction

   // Push is left high after a word is taken, so that a following word with no
   // gap enters on the next edge unless full; anything that waits lowers it first.
   task automatic send_word(psrt_pkg::req_type w);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0)
         send_burst = !send_burst;
      gap = draw_gap(send_burst);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= w;
      push     <= 1'b1;
      do @(posedge clock); while (full);
      track_residency(w);
   endtask

   task automatic settle_block();
      push <= 1'b0;
      while (due_records.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [psrt_pkg::CSR_ADDR_WIDTH-1:0] addr,
                            logic [psrt_pkg::CSR_DATA_WIDTH-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == LIMIT_ADDR)
         state_limit = value[psrt_pkg::LIMIT_WIDTH-1:0];
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_limit_readback();
      logic [psrt_pkg::CSR_DATA_WIDTH-1:0] value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= LIMIT_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      value = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (value !== psrt_pkg::CSR_DATA_WIDTH'(state_limit)) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("limit readback: expected %0d actual %0d", state_limit, value);
      end
   endtask

   task automatic set_limit(logic [psrt_pkg::CSR_DATA_WIDTH-1:0] value);
      settle_block();
      csr_write(LIMIT_ADDR, value);
      check_limit_readback();
   endtask

   task automatic test_flush_after_reset();
      send_word(make_word(psrt_pkg::CMD_FLUSH, psrt_pkg::CLASS_LOGIC, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
   endtask

   task automatic test_logic_domains();
      send_word(make_word(psrt_pkg::CMD_EVENT, psrt_pkg::CLASS_LOGIC, 32'hFFFF_FFFF,
                          32'h0000_0000, 32'd0));
      send_word(make_word(psrt_pkg::CMD_EVENT, psrt_pkg::CLASS_LOGIC, 32'h0000_0000,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_word(make_word(psrt_pkg::CMD_EVENT, psrt_pkg::CLASS_LOGIC, 32'h0000_0000,
                          32'h1B1B_1B1B, 32'd3));
   endtask

   task automatic test_memory_domains();
      send_word(make_word(psrt_pkg::CMD_EVENT, psrt_pkg::CLASS_MEMORY, 32'hFFFF_FFFF,
                          32'h0000_0000, 32'd1));
      send_word(make_word(psrt_pkg::CMD_EVENT, psrt_pkg::CLASS_MEMORY, 32'h0000_0000,
                          32'hFFFF_FFFF, 32'd0));
      send_word(make_word(psrt_pkg::CMD_EVENT, psrt_pkg::CLASS_MEMORY, 32'h1B1B_1B1B,
                          32'hE4E4_E4E4, 32'h8000_0000));
   endtask

   task automatic test_flush_records();
      send_word(make_word(psrt_pkg::CMD_FLUSH, psrt_pkg::CLASS_MEMORY, 32'h0, 32'h0, 32'h0));
      send_word(make_word(psrt_pkg::CMD_EVENT, psrt_pkg::CLASS_LOGIC, 32'h0, 32'h5555_5555,
                          32'd100));
      send_word(make_word(psrt_pkg::CMD_EVENT, psrt_pkg::CLASS_LOGIC, 32'h0, 32'hAAAA_AAAA,
                          32'd7));
      send_word(make_word(psrt_pkg::CMD_FLUSH, psrt_pkg::CLASS_LOGIC, 32'h0, 32'h0, 32'h0));
      send_word(make_word(psrt_pkg::CMD_FLUSH, psrt_pkg::CLASS_LOGIC, 32'h0, 32'h0, 32'h0));
   endtask

   task automatic test_state_limit();
      set_limit(32'd2);
      send_word(make_word(psrt_pkg::CMD_EVENT, psrt_pkg::CLASS_LOGIC, 32'h0, 32'h0020_3040,
                          32'd11));
      send_word(make_word(psrt_pkg::CMD_EVENT, psrt_pkg::CLASS_MEMORY, 32'h5555_5555,
                          32'h0080_0003, 32'd13));
      send_word(make_word(psrt_pkg::CMD_EVENT, psrt_pkg::CLASS_MEMORY, 32'h5555_5555,
                          32'h1111_1111, 32'd9));
      set_limit(32'd0);
      send_word(make_word(psrt_pkg::CMD_EVENT, psrt_pkg::CLASS_LOGIC, 32'h0, 32'h0, 32'd1));
      send_word(make_word(psrt_pkg::CMD_EVENT, psrt_pkg::CLASS_MEMORY, 32'h0, 32'h0, 32'd5));
      send_word(make_word(psrt_pkg::CMD_FLUSH, psrt_pkg::CLASS_LOGIC, 32'h0, 32'h0, 32'h0));
      set_limit(32'd7);
      send_word(make_word(psrt_pkg::CMD_EVENT, psrt_pkg::CLASS_LOGIC, 32'h0, 32'hFFFF_FFFF,
                          32'd2));
      send_word(make_word(psrt_pkg::CMD_FLUSH, psrt_pkg::CLASS_LOGIC, 32'h0, 32'h0, 32'h0));
   endtask

   task automatic test_register_index();
      settle_block();
      csr_write(SPARE_ADDR, 32'd1);
      check_limit_readback();
      send_word(make_word(psrt_pkg::CMD_EVENT, psrt_pkg::CLASS_LOGIC, 32'h0, 32'hFFFF_FFFF,
                          32'd4));
   endtask

   // Mostly gradual state changes below a nonzero limit, with some random noise
   // words and the odd flush in between.
   task automatic test_random_trace(int unsigned count,
                                    logic [psrt_pkg::CSR_DATA_WIDTH-1:0] lim);
      psrt_pkg::req_type w;
      int unsigned       kind;
      set_limit(lim);
      repeat (count) begin
         kind = $urandom_range(0, 99);
         w = make_word(psrt_pkg::CMD_EVENT, 1'($urandom_range(0, 1)), $urandom, $urandom,
                       draw_delta());
         if (kind < 6) begin
            w.command = psrt_pkg::CMD_FLUSH;
         end else if (kind >= 16) begin
            if (w.event_class == psrt_pkg::CLASS_LOGIC) begin
               logic_pattern = mutate_states(logic_pattern, LOGIC_COUNT, state_limit);
               w.states_low  = logic_pattern[31:0];
            end else begin
               memory_pattern = mutate_states(memory_pattern, MEMORY_COUNT, state_limit);
               {w.states_high, w.states_low} = memory_pattern;
            end
         end
         send_word(w);
      end
   endtask

   initial begin : result_checker
      int unsigned stall;
      bit          burst;
      burst = 1'b0;
      pop <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0)
            burst = !burst;
         stall = draw_gap(burst);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         check_record(rsp_data);
      end
   end

   initial begin
      push     <= 1'b0;
      req_data <= '0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      paddr    <= '0;
      pwdata   <= '0;
      reset    <= 1'b1;
      clear_tracker();
      state_limit    = psrt_pkg::LIMIT_RESET;
      logic_pattern  = '0;
      memory_pattern = '0;
      mismatch_count = 0;
      send_burst     = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_flush_after_reset();
      test_logic_domains();
      test_memory_domains();
      test_flush_records();
      test_state_limit();
      test_register_index();
      test_random_trace(170, 32'd4);
      test_random_trace(60, 32'd3);
      test_random_trace(80, 32'd7);
      test_random_trace(50, 32'd2);
      test_random_trace(40, 32'd1);
      test_random_trace(15, 32'd0);

      settle_block();
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
